// File: src/pdr_pkg.sv
// pdr_pkg: shared types and constants of the pwm duty ramp controller
// holds request codes, register indexes, fsm states and the control structs
// no dependencies
package pdr_pkg;

    localparam int DUTY_WIDTH_DEF = 16;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_START    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DUTY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP = 3'd4;

    localparam logic [15:0] FULL_SCALE_RST     = 16'd1023;
    localparam logic [14:0] SPEED_MAX_RST      = 15'd3000;
    localparam logic [15:0] ALPHA_START_RST    = 16'd512;
    localparam logic [15:0] STOP_DUTY_RST      = 16'd0;
    localparam logic [15:0] TICKS_PER_STEP_RST = 16'd20;

    typedef enum logic [1:0] {
        REQ_SPEED = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_START = 2'd2,
        REQ_STOP  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_COMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] full_scale;
        logic [14:0] speed_max;
        logic [15:0] alpha_start;
        logic [15:0] stop_duty;
        logic [15:0] ticks_per_step;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic update;
        logic complement;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// File: src/pdr_cfg.sv
// pdr_cfg: configuration register file of the pwm duty ramp controller
// depends on pdr_pkg for register indexes, reset values and cfg_t
module pdr_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    output pdr_pkg::cfg_t                 cfg
);

    pdr_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_scale     <= pdr_pkg::FULL_SCALE_RST;
            cfg_reg.speed_max      <= pdr_pkg::SPEED_MAX_RST;
            cfg_reg.alpha_start    <= pdr_pkg::ALPHA_START_RST;
            cfg_reg.stop_duty      <= pdr_pkg::STOP_DUTY_RST;
            cfg_reg.ticks_per_step <= pdr_pkg::TICKS_PER_STEP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                pdr_pkg::CFG_FULL_SCALE:     cfg_reg.full_scale     <= cfg_data;
                pdr_pkg::CFG_SPEED_MAX:      cfg_reg.speed_max      <= cfg_data[14:0];
                pdr_pkg::CFG_ALPHA_START:    cfg_reg.alpha_start    <= cfg_data;
                pdr_pkg::CFG_STOP_DUTY:      cfg_reg.stop_duty      <= cfg_data;
                pdr_pkg::CFG_TICKS_PER_STEP: cfg_reg.ticks_per_step <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: src/pdr_ctrl.sv
// pdr_ctrl: sequencing state machine of the pwm duty ramp controller
// depends on pdr_pkg for state_t, req_t, cmd_t and status_t
module pdr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  pdr_pkg::status_t status,
    output pdr_pkg::cmd_t    cmd
);

    pdr_pkg::state_t state_reg;
    pdr_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pdr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (pdr_pkg::req_t'(s_req_type) == pdr_pkg::REQ_SPEED) begin
                        state_next = pdr_pkg::ST_MUL;
                    end else begin
                        state_next = pdr_pkg::ST_UPDATE;
                    end
                end
            end
            pdr_pkg::ST_MUL:    state_next = pdr_pkg::ST_DIV;
            pdr_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = pdr_pkg::ST_UPDATE;
                end
            end
            pdr_pkg::ST_UPDATE: state_next = pdr_pkg::ST_COMP;
            pdr_pkg::ST_COMP:   state_next = pdr_pkg::ST_DONE;
            pdr_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = pdr_pkg::ST_IDLE;
                end
            end
            default:            state_next = pdr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            pdr_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            pdr_pkg::ST_MUL:    cmd.mul        = 1'b1;
            pdr_pkg::ST_DIV:    cmd.div_step   = 1'b1;
            pdr_pkg::ST_UPDATE: cmd.update     = 1'b1;
            pdr_pkg::ST_COMP:   cmd.complement = 1'b1;
            pdr_pkg::ST_DONE:   cmd.publish    = status.out_free;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_speed_goes_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && pdr_pkg::req_t'(s_req_type) == pdr_pkg::REQ_SPEED)
        |=> state_reg == pdr_pkg::ST_MUL)
        else $error("set speed word did not start the multiply");

    a_other_goes_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && pdr_pkg::req_t'(s_req_type) != pdr_pkg::REQ_SPEED)
        |=> state_reg == pdr_pkg::ST_UPDATE)
        else $error("tick, start or stop word did not go straight to update");

    a_div_ends_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pdr_pkg::ST_DIV && status.div_last) |=> state_reg == pdr_pkg::ST_UPDATE)
        else $error("divider finished but update was skipped");

    a_held_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pdr_pkg::ST_DONE && !status.out_free) |=> state_reg == pdr_pkg::ST_DONE)
        else $error("left done while the output word was still held");
`endif

endmodule

// File: src/pdr_datapath.sv
// pdr_datapath: clamp, multiplier, restoring divider, ramp state and output register
// depends on pdr_pkg for req_t, cfg_t, cmd_t and status_t
module pdr_datapath #(
    parameter int DUTY_WIDTH = pdr_pkg::DUTY_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pdr_pkg::cfg_t      cfg,
    input  pdr_pkg::cmd_t      cmd,
    output pdr_pkg::status_t   status,
    input  logic [1:0]         s_req_type,
    input  logic signed [15:0] s_speed_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_duty_a,
    output logic [15:0]        m_duty_b,
    output logic               m_outputs_on,
    output logic               m_at_target
);

    localparam int EW = DUTY_WIDTH + 16;

    pdr_pkg::req_t                  req_reg;
    logic [15:0]                    sum_reg;
    logic [16:0]                    rem_reg;
    logic [31:0]                    quo_reg;
    logic [pdr_pkg::DIV_CNT_W-1:0]  cnt_reg;

    logic [DUTY_WIDTH-1:0]          cur_reg;
    logic [DUTY_WIDTH-1:0]          comp_reg;
    logic [DUTY_WIDTH-1:0]          tgt_reg;
    logic [15:0]                    tick_reg;
    logic                           run_reg;
    logic                           comp_pend_reg;

    logic                           m_valid_reg;
    logic [15:0]                    duty_a_reg;
    logic [15:0]                    duty_b_reg;
    logic                           on_reg;
    logic                           at_tgt_reg;

    logic [14:0]                    v_clamp;
    logic [16:0]                    rem_sh;
    logic [16:0]                    divisor;
    logic                           div_ge;
    logic [15:0]                    limit;
    logic [15:0]                    tick_inc;
    logic [EW-1:0]                  am_ext;
    logic [EW-1:0]                  cur_ext;
    logic [EW-1:0]                  comp_diff;
    logic [EW-1:0]                  quo_ext;
    logic [EW-1:0]                  half_ext;
    logic [EW-1:0]                  start_ext;
    logic [EW-1:0]                  min_ext;
    logic [EW-1:0]                  out_a_ext;
    logic [EW-1:0]                  out_b_ext;

    // clamp to 0..speed_max
    always_comb begin
        if (s_speed_cmd[15]) begin
            v_clamp = '0;
        end else if (s_speed_cmd[14:0] > cfg.speed_max) begin
            v_clamp = cfg.speed_max;
        end else begin
            v_clamp = s_speed_cmd[14:0];
        end
    end

    assign divisor = {1'b0, cfg.speed_max, 1'b0};
    assign rem_sh  = {rem_reg[15:0], quo_reg[31]};
    assign div_ge  = rem_sh >= divisor;

    assign limit    = (cfg.ticks_per_step == 16'd0) ? 16'd1 : cfg.ticks_per_step;
    assign tick_inc = tick_reg + 16'd1;

    assign am_ext    = EW'(cfg.full_scale);
    assign cur_ext   = EW'(cur_reg);
    assign comp_diff = am_ext - cur_ext;
    assign quo_ext   = EW'(quo_reg[15:0]);
    assign half_ext  = EW'(cfg.full_scale[15:1]);
    assign start_ext = EW'(cfg.alpha_start);
    assign min_ext   = EW'(cfg.stop_duty);
    assign out_a_ext = EW'(cur_reg);
    assign out_b_ext = EW'(comp_reg);

    assign status.div_last = (cnt_reg == pdr_pkg::DIV_CNT_W'(pdr_pkg::DIV_STEPS - 1));
    assign status.out_free = !m_valid_reg || m_ready;

    // request capture, multiply and one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= pdr_pkg::req_t'(s_req_type);
            sum_reg <= 16'(cfg.speed_max) + 16'(v_clamp);
        end
        if (cmd.mul) begin
            quo_reg <= sum_reg * cfg.full_scale;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? (rem_sh - divisor) : rem_sh;
            quo_reg <= {quo_reg[30:0], div_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // ramp state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            comp_reg      <= '0;
            tgt_reg       <= '0;
            tick_reg      <= '0;
            run_reg       <= 1'b0;
            comp_pend_reg <= 1'b0;
        end else if (cmd.update) begin
            case (req_reg)
                pdr_pkg::REQ_SPEED: begin
                    comp_pend_reg <= 1'b0;
                    if (cfg.speed_max == 15'd0) begin
                        tgt_reg <= half_ext[DUTY_WIDTH-1:0];
                    end else begin
                        tgt_reg <= quo_ext[DUTY_WIDTH-1:0];
                    end
                end
                pdr_pkg::REQ_TICK: begin
                    if (tick_inc >= limit) begin
                        tick_reg      <= '0;
                        comp_pend_reg <= 1'b1;
                        if (cur_reg < tgt_reg) begin
                            cur_reg <= cur_reg + 1'b1;
                        end else if (cur_reg > tgt_reg) begin
                            cur_reg <= cur_reg - 1'b1;
                        end
                    end else begin
                        tick_reg      <= tick_inc;
                        comp_pend_reg <= 1'b0;
                    end
                end
                pdr_pkg::REQ_START: begin
                    cur_reg       <= start_ext[DUTY_WIDTH-1:0];
                    tgt_reg       <= start_ext[DUTY_WIDTH-1:0];
                    tick_reg      <= '0;
                    run_reg       <= 1'b1;
                    comp_pend_reg <= 1'b1;
                end
                pdr_pkg::REQ_STOP: begin
                    cur_reg       <= min_ext[DUTY_WIDTH-1:0];
                    comp_reg      <= min_ext[DUTY_WIDTH-1:0];
                    tgt_reg       <= min_ext[DUTY_WIDTH-1:0];
                    tick_reg      <= '0;
                    run_reg       <= 1'b0;
                    comp_pend_reg <= 1'b0;
                end
                default: ;
            endcase
        end else if (cmd.complement && comp_pend_reg) begin
            // complement saturates at zero above full scale
            comp_reg <= (cur_ext > am_ext) ? '0 : comp_diff[DUTY_WIDTH-1:0];
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.publish) begin
            duty_a_reg <= out_a_ext[15:0];
            duty_b_reg <= out_b_ext[15:0];
            on_reg     <= run_reg;
            at_tgt_reg <= (cur_reg == tgt_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_duty_a     = duty_a_reg;
    assign m_duty_b     = duty_b_reg;
    assign m_outputs_on = on_reg;
    assign m_at_target  = at_tgt_reg;

`ifndef SYNTHESIS
    a_run_only_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.update |=> $stable(run_reg))
        else $error("running flag changed outside an update");

    a_target_only_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.update |=> $stable(tgt_reg))
        else $error("target duty changed outside an update");

    a_publish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(duty_a_reg)))
        else $error("held output word was overwritten");
`endif

endmodule

// File: src/pwm_duty_ramp_controller.sv
// pwm_duty_ramp_controller: top level of the slew-rate limited pwm duty ramp
// depends on pdr_pkg, pdr_cfg, pdr_ctrl and pdr_datapath
//
// Each accepted word (set speed, tick, start, stop) returns one result word with both
// compare values, the run flag and an at-target flag. A set-speed word clamps the speed,
// multiplies by the full scale compare value and divides by 2*speed_max in a 32-step
// restoring divider; tick, start and stop words go straight to the ramp update. One word
// is in work at a time; a finished result waits in the output register, and while it is
// not taken the next result holds the block. Configuration writes are taken in any cycle
// and belong in idle periods.
module pwm_duty_ramp_controller #(
    parameter int DUTY_WIDTH = pdr_pkg::DUTY_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic signed [15:0]            s_speed_cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_duty_a,
    output logic [15:0]                   m_duty_b,
    output logic                          m_outputs_on,
    output logic                          m_at_target,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    pdr_pkg::cfg_t    cfg;
    pdr_pkg::cmd_t    cmd;
    pdr_pkg::status_t status;

    pdr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .status     (status),
        .cmd        (cmd)
    );

    pdr_datapath #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .s_req_type   (s_req_type),
        .s_speed_cmd  (s_speed_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_duty_a     (m_duty_a),
        .m_duty_b     (m_duty_b),
        .m_outputs_on (m_outputs_on),
        .m_at_target  (m_at_target)
    );

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for pwm_duty_ramp_controller
// directed table then random phases; every result checked against the table or ramp predictor
// depends on pdr_pkg and the pwm_duty_ramp_controller rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic        outputs_on;
        logic        at_target;
    } duty_word_t;

    typedef struct {
        bit                            is_reg;
        logic [pdr_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [15:0]                   reg_val;
        pdr_pkg::req_t                 req;
        logic signed [15:0]            spd;
        bit                            typed;
        duty_word_t                    want;
    } plan_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_req_type = 2'd0;
    logic signed [15:0]            s_speed_cmd = 16'sd0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [15:0]                   m_duty_a;
    logic [15:0]                   m_duty_b;
    logic                          m_outputs_on;
    logic                          m_at_target;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [pdr_pkg::CFG_IDX_W-1:0] cfg_index = pdr_pkg::CFG_FULL_SCALE;
    logic [15:0]                   cfg_data = 16'd0;

    // predictor copy of registers and ramp state
    logic [15:0] amax_r;
    logic [14:0] smax_r;
    logic [15:0] start_r;
    logic [15:0] min_r;
    logic [15:0] tps_r;
    logic [15:0] duty_now;
    logic [15:0] duty_comp;
    logic [15:0] duty_goal;
    int unsigned tick_cnt;
    logic        run_on;

    duty_word_t duty_words_due[$];
    int         mismatches = 0;
    int         rx_idle_pct = 0;
    int         hold_reqs = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    pwm_duty_ramp_controller DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_speed_cmd (s_speed_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_duty_a    (m_duty_a),
        .m_duty_b    (m_duty_b),
        .m_outputs_on(m_outputs_on),
        .m_at_target (m_at_target),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [15:0] comp_duty(logic [15:0] d);
        return (d > amax_r) ? 16'd0 : amax_r - d;
    endfunction

    function automatic logic [15:0] speed_to_target(logic signed [15:0] spd);
        longint            v;
        longint unsigned   num;
        if (smax_r == 15'd0) begin
            return amax_r >> 1;
        end
        v = spd;
        if (v < 0) begin
            v = 0;
        end
        if (v > longint'(smax_r)) begin
            v = longint'(smax_r);
        end
        num = (64'(smax_r) + 64'(v)) * 64'(amax_r);
        return 16'(num / (64'd2 * 64'(smax_r)));
    endfunction

    function automatic duty_word_t ramp_step(pdr_pkg::req_t req, logic signed [15:0] spd);
        int unsigned lim;
        duty_word_t  w;
        case (req)
            pdr_pkg::REQ_SPEED: begin
                duty_goal = speed_to_target(spd);
            end
            pdr_pkg::REQ_TICK: begin
                lim = (tps_r == 16'd0) ? 1 : tps_r;
                tick_cnt = tick_cnt + 1;
                if (tick_cnt >= lim) begin
                    tick_cnt = 0;
                    if (duty_now < duty_goal) begin
                        duty_now = duty_now + 16'd1;
                    end else if (duty_now > duty_goal) begin
                        duty_now = duty_now - 16'd1;
                    end
                    duty_comp = comp_duty(duty_now);
                end
            end
            pdr_pkg::REQ_START: begin
                duty_now = start_r;
                duty_comp = comp_duty(duty_now);
                duty_goal = duty_now;
                tick_cnt = 0;
                run_on = 1'b1;
            end
            default: begin
                duty_now = min_r;
                duty_comp = min_r;
                duty_goal = duty_now;
                tick_cnt = 0;
                run_on = 1'b0;
            end
        endcase
        w.duty_a = duty_now;
        w.duty_b = duty_comp;
        w.outputs_on = run_on;
        w.at_target = (duty_now == duty_goal);
        return w;
    endfunction

    function automatic plan_row_t blank_row();
        plan_row_t r;
        r.is_reg = 1'b0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.req = pdr_pkg::REQ_TICK;
        r.spd = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [pdr_pkg::CFG_IDX_W-1:0] idx,
                                          logic [15:0] val);
        plan_row_t r;
        r = blank_row();
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic plan_row_t word_row(pdr_pkg::req_t req, logic signed [15:0] spd);
        plan_row_t r;
        r = blank_row();
        r.req = req;
        r.spd = spd;
        return r;
    endfunction

    function automatic plan_row_t known_row(pdr_pkg::req_t req, logic signed [15:0] spd,
                                            duty_word_t want);
        plan_row_t r;
        r = word_row(req, spd);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    task automatic send_word(pdr_pkg::req_t req, logic signed [15:0] spd, bit typed,
                             duty_word_t want);
        duty_word_t due;
        s_valid <= 1'b1;
        s_req_type <= req;
        s_speed_cmd <= spd;
        do @(posedge aclk); while (!s_ready);
        due = ramp_step(req, spd);
        duty_words_due.push_back(typed ? want : due);
    endtask

    task automatic write_reg(logic [pdr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pdr_pkg::CFG_FULL_SCALE:     amax_r = val;
            pdr_pkg::CFG_SPEED_MAX:      smax_r = val[14:0];
            pdr_pkg::CFG_ALPHA_START:    start_r = val;
            pdr_pkg::CFG_STOP_DUTY:      min_r = val;
            pdr_pkg::CFG_TICKS_PER_STEP: tps_r = val;
            default:                     ;
        endcase
    endtask

    // stop offering words and wait for every result to come back
    task automatic settle();
        s_valid <= 1'b0;
        while (duty_words_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        duty_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_words_due.size() == 0) begin
                $display("%0t: unexpected word duty_a=%0d duty_b=%0d on=%0b at=%0b",
                         $time, m_duty_a, m_duty_b, m_outputs_on, m_at_target);
                mismatches++;
            end else begin
                want = duty_words_due.pop_front();
                if (m_duty_a !== want.duty_a) begin
                    $display("%0t: duty_a expected %0d actual %0d",
                             $time, want.duty_a, m_duty_a);
                    mismatches++;
                end
                if (m_duty_b !== want.duty_b) begin
                    $display("%0t: duty_b expected %0d actual %0d",
                             $time, want.duty_b, m_duty_b);
                    mismatches++;
                end
                if (m_outputs_on !== want.outputs_on) begin
                    $display("%0t: outputs_on expected %0b actual %0b",
                             $time, want.outputs_on, m_outputs_on);
                    mismatches++;
                end
                if (m_at_target !== want.at_target) begin
                    $display("%0t: at_target expected %0b actual %0b",
                             $time, want.at_target, m_at_target);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        plan_row_t          plan[$];
        int                 tx_idle;
        int                 v;
        int                 pick;
        logic [15:0]        set_amax, set_smax, set_start, set_min, set_tps;
        pdr_pkg::req_t      req;
        logic signed [15:0] spd;

        amax_r = pdr_pkg::FULL_SCALE_RST;
        smax_r = pdr_pkg::SPEED_MAX_RST;
        start_r = pdr_pkg::ALPHA_START_RST;
        min_r = pdr_pkg::STOP_DUTY_RST;
        tps_r = pdr_pkg::TICKS_PER_STEP_RST;
        duty_now = 16'd0;
        duty_comp = 16'd0;
        duty_goal = 16'd0;
        tick_cnt = 0;
        run_on = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        plan.push_back(known_row(pdr_pkg::REQ_TICK, 16'sd0,
                                 duty_word_t'{16'd0, 16'd0, 1'b0, 1'b1}));
        plan.push_back(known_row(pdr_pkg::REQ_START, 16'sd0,
                                 duty_word_t'{16'd512, 16'd511, 1'b1, 1'b1}));
        plan.push_back(known_row(pdr_pkg::REQ_SPEED, 16'sd32767,
                                 duty_word_t'{16'd512, 16'd511, 1'b1, 1'b0}));
        plan.push_back(known_row(pdr_pkg::REQ_SPEED, -16'sd32768,
                                 duty_word_t'{16'd512, 16'd511, 1'b1, 1'b0}));
        plan.push_back(known_row(pdr_pkg::REQ_SPEED, 16'sd0,
                                 duty_word_t'{16'd512, 16'd511, 1'b1, 1'b0}));
        plan.push_back(word_row(pdr_pkg::REQ_SPEED, 16'sd3000));
        plan.push_back(reg_row(pdr_pkg::CFG_TICKS_PER_STEP, 16'd1));
        plan.push_back(word_row(pdr_pkg::REQ_TICK, 16'sd0));
        plan.push_back(word_row(pdr_pkg::REQ_TICK, 16'sd0));
        plan.push_back(reg_row(pdr_pkg::CFG_TICKS_PER_STEP, 16'd0));
        plan.push_back(word_row(pdr_pkg::REQ_TICK, 16'sd0));
        plan.push_back(known_row(pdr_pkg::REQ_STOP, 16'sd0,
                                 duty_word_t'{16'd0, 16'd0, 1'b0, 1'b1}));
        // ramp keeps moving with outputs off
        plan.push_back(word_row(pdr_pkg::REQ_SPEED, 16'sd1500));
        plan.push_back(word_row(pdr_pkg::REQ_TICK, 16'sd0));
        plan.push_back(word_row(pdr_pkg::REQ_TICK, 16'sd0));
        plan.push_back(word_row(pdr_pkg::REQ_SPEED, -16'sd1));
        plan.push_back(reg_row(pdr_pkg::CFG_SPEED_MAX, 16'd0));
        plan.push_back(word_row(pdr_pkg::REQ_SPEED, -16'sd5));
        // duty above full scale saturates the complement
        plan.push_back(reg_row(pdr_pkg::CFG_ALPHA_START, 16'hFFFF));
        plan.push_back(reg_row(pdr_pkg::CFG_FULL_SCALE, 16'd100));
        plan.push_back(known_row(pdr_pkg::REQ_START, 16'sd0,
                                 duty_word_t'{16'hFFFF, 16'd0, 1'b1, 1'b1}));
        plan.push_back(word_row(pdr_pkg::REQ_TICK, 16'sd0));
        plan.push_back(reg_row(pdr_pkg::CFG_STOP_DUTY, 16'hFFFF));
        plan.push_back(known_row(pdr_pkg::REQ_STOP, 16'sd0,
                                 duty_word_t'{16'hFFFF, 16'hFFFF, 1'b0, 1'b1}));
        plan.push_back(reg_row(pdr_pkg::CFG_SPEED_MAX, 16'd32767));
        plan.push_back(reg_row(pdr_pkg::CFG_FULL_SCALE, 16'hFFFF));
        plan.push_back(word_row(pdr_pkg::REQ_SPEED, 16'sd32767));
        plan.push_back(word_row(pdr_pkg::REQ_TICK, 16'sd0));

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (i == 0 || !plan[i-1].is_reg) begin
                    settle();
                end
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                if (i == plan.size() - 1 || !plan[i+1].is_reg) begin
                    cfg_valid <= 1'b0;
                end
            end else begin
                send_word(plan[i].req, plan[i].spd, plan[i].typed, plan[i].want);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    set_amax = 16'd20; set_smax = 16'd100; set_start = 16'd10;
                    set_min = 16'd0; set_tps = 16'd1;
                end
                1: begin
                    set_amax = 16'd1; set_smax = 16'd1; set_start = 16'd0;
                    set_min = 16'd1; set_tps = 16'd2;
                end
                2: begin
                    set_amax = 16'hFFFF; set_smax = 16'hFFFF; set_start = 16'hFFFF;
                    set_min = 16'hFFFF; set_tps = 16'hFFFF;
                end
                3: begin
                    set_amax = 16'd37; set_smax = 16'd0; set_start = 16'd50;
                    set_min = 16'd3; set_tps = 16'd0;
                end
                4: begin
                    set_amax = 16'($urandom_range(1, 64));
                    set_smax = 16'($urandom_range(1, 32767));
                    set_start = 16'($urandom_range(0, 80));
                    set_min = 16'($urandom_range(0, 80));
                    set_tps = 16'($urandom_range(1, 4));
                end
                default: begin
                    set_amax = 16'($urandom); set_smax = 16'($urandom);
                    set_start = 16'($urandom); set_min = 16'($urandom);
                    set_tps = 16'($urandom_range(1, 3));
                end
            endcase
            settle();
            write_reg(pdr_pkg::CFG_FULL_SCALE, set_amax);
            write_reg(pdr_pkg::CFG_SPEED_MAX, set_smax);
            write_reg(pdr_pkg::CFG_ALPHA_START, set_start);
            write_reg(pdr_pkg::CFG_STOP_DUTY, set_min);
            write_reg(pdr_pkg::CFG_TICKS_PER_STEP, set_tps);
            cfg_valid <= 1'b0;

            if (phase < 2) begin
                tx_idle = 7;
                rx_idle_pct <= 76;
            end else if (phase < 4) begin
                tx_idle = 76;
                rx_idle_pct <= 7;
            end else begin
                tx_idle = 0;
                rx_idle_pct <= 0;
            end

            for (int n = 0; n < 305; n++) begin
                if (n == 100) begin
                    hold_reqs <= hold_reqs + 1;
                end
                if (n == 200) begin
                    settle();
                end
                if ($urandom_range(0, 99) < tx_idle) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 45)) @(posedge aclk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    req = pdr_pkg::REQ_TICK;
                end else if (pick < 92) begin
                    req = pdr_pkg::REQ_SPEED;
                end else if (pick < 96) begin
                    req = pdr_pkg::REQ_START;
                end else begin
                    req = pdr_pkg::REQ_STOP;
                end
                if ($urandom_range(0, 1) == 0) begin
                    spd = 16'($urandom);
                end else begin
                    v = int'($urandom_range(0, smax_r + smax_r / 4 + 2)) - int'(smax_r / 8) - 1;
                    spd = v[15:0];
                end
                send_word(req, spd, 1'b0, '0);
            end
        end

        settle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/pdr_pkg.sv
src/pdr_cfg.sv
src/pdr_ctrl.sv
src/pdr_datapath.sv
src/pwm_duty_ramp_controller.sv
dv/tb.sv
